FILE: hdl/tsg_pkg.sv
package tsg_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_valid;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  char_code;
    logic [15:0] start_offset;
    logic [15:0] end_offset;
    logic [2:0]  error_code;
    logic        last_of_run;
  } res_item_t;

  // Up to three result words leave the scanner per accepted input word.
  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [1:0]                 cnt;
    res_item_t [MaxRes-1:0]     res;
  } res_group_t;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_IDENT     = 4'd1,
    MODE_NUMBER    = 4'd2,
    MODE_CMP       = 4'd3,
    MODE_DASH      = 4'd4,
    MODE_DASH_AMP  = 4'd5,
    MODE_COLON     = 4'd6,
    MODE_COLON_AMP = 4'd7,
    MODE_GROUP     = 4'd8
  } scan_mode_e;

  localparam logic [4:0] KIND_EOF       = 5'd0;
  localparam logic [4:0] KIND_IDENT     = 5'd1;
  localparam logic [4:0] KIND_NUMBER    = 5'd2;
  localparam logic [4:0] KIND_EQ        = 5'd3;
  localparam logic [4:0] KIND_NE        = 5'd4;
  localparam logic [4:0] KIND_LE        = 5'd5;
  localparam logic [4:0] KIND_GE        = 5'd6;
  localparam logic [4:0] KIND_ARROW     = 5'd7;
  localparam logic [4:0] KIND_FAT_ARROW = 5'd8;
  localparam logic [4:0] KIND_DASH_COL  = 5'd9;
  localparam logic [4:0] KIND_DASH_AMP  = 5'd10;
  localparam logic [4:0] KIND_DASH_AMP2 = 5'd11;
  localparam logic [4:0] KIND_COL_COL   = 5'd12;
  localparam logic [4:0] KIND_COL_AMP   = 5'd13;
  localparam logic [4:0] KIND_COL_AMP2  = 5'd14;
  localparam logic [4:0] KIND_COL_GT    = 5'd15;
  localparam logic [4:0] KIND_PAREN     = 5'd16;
  localparam logic [4:0] KIND_SQUARE    = 5'd17;
  localparam logic [4:0] KIND_BRACE     = 5'd18;
  localparam logic [4:0] KIND_SINGLE    = 5'd19;
  localparam logic [4:0] KIND_ERROR     = 5'd20;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_STRAY_BRACE  = 3'd1;
  localparam logic [2:0] ERR_STRAY_SQUARE = 3'd2;
  localparam logic [2:0] ERR_STRAY_PAREN  = 3'd3;
  localparam logic [2:0] ERR_OPEN_AT_END  = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW     = 3'd5;

  localparam int unsigned QueueDepth = 8;

endpackage

FILE: hdl/tsg_front.sv
module tsg_front #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned DEPTH_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  tsg_pkg::in_item_t   item_i,
  output tsg_pkg::res_group_t grp_o
);
  import tsg_pkg::*;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [DEPTH_BITS-1:0]  lvl_t;

  localparam logic [7:0] ChBslash = 8'h5C;

  scan_mode_e mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  off_t       tstart_q, tstart_d, pos_q, pos_d;
  logic       dot_q, dot_d, esc_q, esc_d, drop_q, drop_d;
  lvl_t       bl_q, bl_d, sl_q, sl_d, pl_q, pl_d;

  function automatic res_item_t mk(logic [4:0] k, logic [7:0] ch, off_t s, off_t e,
                                   logic [2:0] er);
    res_item_t r;
    r.token_kind   = k;
    r.char_code    = ch;
    r.start_offset = 16'(s);
    r.end_offset   = 16'(e);
    r.error_code   = er;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    off_t       p, pn, s1;
    logic       run_idle, run_grp;
    logic [2:0] err;
    logic [1:0] n;
    res_item_t [MaxRes-1:0] res;
    c        = item_i.in_char;
    p        = pos_q;
    pn       = pos_q + off_t'(1);
    s1       = tstart_q + off_t'(1);
    run_idle = 1'b0;
    run_grp  = 1'b0;
    err      = ERR_NONE;
    n        = 2'd0;
    res      = '0;
    mode_d   = mode_q;
    pend_d   = pend_q;
    tstart_d = tstart_q;
    pos_d    = pos_q;
    dot_d    = dot_q;
    esc_d    = esc_q;
    drop_d   = drop_q;
    bl_d     = bl_q;
    sl_d     = sl_q;
    pl_d     = pl_q;

    if (item_i.char_valid) begin
      pos_d = pn;
      if (!drop_q) begin
        if (mode_q == MODE_GROUP) begin
          run_grp = 1'b1;
        end else if (mode_q == MODE_IDLE) begin
          run_idle = 1'b1;
        end else begin
          // Held token: consume the byte or close the token and rescan it.
          run_idle = 1'b1;
          mode_d   = MODE_IDLE;
          case (mode_q)
            MODE_IDENT: begin
              if ((c inside {["0":"9"], ["a":"z"], ["A":"Z"]}) || c == "_") begin
                run_idle = 1'b0;
                mode_d   = MODE_IDENT;
              end else begin
                res[n] = mk(KIND_IDENT, 8'd0, tstart_q, p, ERR_NONE); n = n + 2'd1;
              end
            end
            MODE_NUMBER: begin
              if ((c == "." && !dot_q) || (c inside {["0":"9"], ["a":"z"], ["A":"Z"]})) begin
                if (c == ".") dot_d = 1'b1;
                run_idle = 1'b0;
                mode_d   = MODE_NUMBER;
              end else begin
                res[n] = mk(KIND_NUMBER, 8'd0, tstart_q, p, ERR_NONE); n = n + 2'd1;
              end
            end
            MODE_CMP: begin
              if (c == "=") begin
                run_idle = 1'b0;
                res[n] = mk(pend_q == "=" ? KIND_EQ : pend_q == "!" ? KIND_NE :
                            pend_q == "<" ? KIND_LE : KIND_GE, 8'd0, tstart_q, pn, ERR_NONE);
                n = n + 2'd1;
              end else if (c == ">" && pend_q == "=") begin
                run_idle = 1'b0;
                res[n] = mk(KIND_FAT_ARROW, 8'd0, tstart_q, pn, ERR_NONE); n = n + 2'd1;
              end else begin
                res[n] = mk(KIND_SINGLE, pend_q, tstart_q, s1, ERR_NONE); n = n + 2'd1;
              end
            end
            MODE_DASH, MODE_COLON: begin
              if (c == "&") begin
                run_idle = 1'b0;
                mode_d = (mode_q == MODE_DASH) ? MODE_DASH_AMP : MODE_COLON_AMP;
              end else if (c == ">") begin
                run_idle = 1'b0;
                res[n] = mk((mode_q == MODE_DASH) ? KIND_ARROW : KIND_COL_GT, 8'd0,
                            tstart_q, pn, ERR_NONE);
                n = n + 2'd1;
              end else if (c == ":") begin
                run_idle = 1'b0;
                res[n] = mk((mode_q == MODE_DASH) ? KIND_DASH_COL : KIND_COL_COL, 8'd0,
                            tstart_q, pn, ERR_NONE);
                n = n + 2'd1;
              end else begin
                res[n] = mk(KIND_SINGLE, (mode_q == MODE_DASH) ? "-" : ":", tstart_q, s1,
                            ERR_NONE);
                n = n + 2'd1;
              end
            end
            MODE_DASH_AMP, MODE_COLON_AMP: begin
              if (c == "&") begin
                run_idle = 1'b0;
                res[n] = mk((mode_q == MODE_DASH_AMP) ? KIND_DASH_AMP2 : KIND_COL_AMP2,
                            8'd0, tstart_q, pn, ERR_NONE);
                n = n + 2'd1;
              end else begin
                res[n] = mk((mode_q == MODE_DASH_AMP) ? KIND_DASH_AMP : KIND_COL_AMP,
                            8'd0, tstart_q, p, ERR_NONE);
                n = n + 2'd1;
              end
            end
            default: ;
          endcase
        end

        if (run_idle) begin
          tstart_d = p;
          if (c == " " || (c inside {[8'd9:8'd13]})) begin
            mode_d = MODE_IDLE;
          end else if (c inside {["0":"9"]}) begin
            mode_d = MODE_NUMBER;
            dot_d  = 1'b0;
          end else if ((c inside {["a":"z"], ["A":"Z"]}) || c == "_") begin
            mode_d = MODE_IDENT;
          end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
            mode_d = MODE_CMP;
            pend_d = c;
          end else if (c == "-") begin
            mode_d = MODE_DASH;
          end else if (c == ":") begin
            mode_d = MODE_COLON;
          end else if (c == "(" || c == "[" || c == "{") begin
            bl_d    = '0;
            sl_d    = '0;
            pl_d    = '0;
            esc_d   = 1'b0;
            pend_d  = c;
            mode_d  = MODE_GROUP;
            run_grp = 1'b1;
          end else begin
            res[n] = mk(KIND_SINGLE, c, p, pn, ERR_NONE); n = n + 2'd1;
          end
        end

        if (run_grp) begin
          if (esc_d) begin
            esc_d = 1'b0;
          end else if (c == ChBslash) begin
            esc_d = 1'b1;
          end else begin
            if (c == "{") begin
              if (&bl_d) err = ERR_OVERFLOW; else bl_d = bl_d + lvl_t'(1);
            end else if (c == "}") begin
              if (bl_d == '0) err = ERR_STRAY_BRACE; else bl_d = bl_d - lvl_t'(1);
            end else if (bl_d == '0) begin
              if (c == "[") begin
                if (&sl_d) err = ERR_OVERFLOW; else sl_d = sl_d + lvl_t'(1);
              end else if (c == "]") begin
                if (sl_d == '0) err = ERR_STRAY_SQUARE; else sl_d = sl_d - lvl_t'(1);
              end else if (sl_d == '0) begin
                if (c == "(") begin
                  if (&pl_d) err = ERR_OVERFLOW; else pl_d = pl_d + lvl_t'(1);
                end else if (c == ")") begin
                  if (pl_d == '0) err = ERR_STRAY_PAREN; else pl_d = pl_d - lvl_t'(1);
                end
              end
            end
            if (err != ERR_NONE) begin
              res[n] = mk(KIND_ERROR, 8'd0, tstart_d, pn, err); n = n + 2'd1;
              bl_d = '0; sl_d = '0; pl_d = '0; esc_d = 1'b0;
              mode_d = MODE_IDLE;
              drop_d = 1'b1;
            end else if (bl_d == '0 && sl_d == '0 && pl_d == '0) begin
              res[n] = mk(pend_d == "(" ? KIND_PAREN : pend_d == "[" ? KIND_SQUARE : KIND_BRACE,
                          8'd0, tstart_d + off_t'(1), p, ERR_NONE);
              n = n + 2'd1;
              mode_d = MODE_IDLE;
              esc_d  = 1'b0;
            end
          end
        end
      end
    end

    if (item_i.text_last) begin
      // Flush the held token, then close the text with eof.
      if (!drop_d) begin
        case (mode_d)
          MODE_IDENT:  begin res[n] = mk(KIND_IDENT, 8'd0, tstart_d, pos_d, ERR_NONE);
                             n = n + 2'd1; end
          MODE_NUMBER: begin res[n] = mk(KIND_NUMBER, 8'd0, tstart_d, pos_d, ERR_NONE);
                             n = n + 2'd1; end
          MODE_CMP:    begin res[n] = mk(KIND_SINGLE, pend_d, tstart_d,
                                         tstart_d + off_t'(1), ERR_NONE); n = n + 2'd1; end
          MODE_DASH:   begin res[n] = mk(KIND_SINGLE, "-", tstart_d,
                                         tstart_d + off_t'(1), ERR_NONE); n = n + 2'd1; end
          MODE_COLON:  begin res[n] = mk(KIND_SINGLE, ":", tstart_d,
                                         tstart_d + off_t'(1), ERR_NONE); n = n + 2'd1; end
          MODE_DASH_AMP:  begin res[n] = mk(KIND_DASH_AMP, 8'd0, tstart_d, pos_d, ERR_NONE);
                                n = n + 2'd1; end
          MODE_COLON_AMP: begin res[n] = mk(KIND_COL_AMP, 8'd0, tstart_d, pos_d, ERR_NONE);
                                n = n + 2'd1; end
          MODE_GROUP:  begin res[n] = mk(KIND_ERROR, 8'd0, tstart_d, pos_d, ERR_OPEN_AT_END);
                             n = n + 2'd1; end
          default: ;
        endcase
      end
      res[n] = mk(KIND_EOF, 8'd0, pos_d, pos_d, ERR_NONE); n = n + 2'd1;
      mode_d   = MODE_IDLE;
      pend_d   = '0;
      tstart_d = '0;
      pos_d    = '0;
      dot_d    = 1'b0;
      esc_d    = 1'b0;
      drop_d   = 1'b0;
      bl_d     = '0;
      sl_d     = '0;
      pl_d     = '0;
    end

    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
    grp_o.cnt = n;
    grp_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= '0;
      tstart_q <= '0;
      pos_q    <= '0;
      dot_q    <= 1'b0;
      esc_q    <= 1'b0;
      drop_q   <= 1'b0;
      bl_q     <= '0;
      sl_q     <= '0;
      pl_q     <= '0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      tstart_q <= tstart_d;
      pos_q    <= pos_d;
      dot_q    <= dot_d;
      esc_q    <= esc_d;
      drop_q   <= drop_d;
      bl_q     <= bl_d;
      sl_q     <= sl_d;
      pl_q     <= pl_d;
    end
  end

endmodule

FILE: hdl/tsg_queue.sv
module tsg_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  tsg_pkg::res_group_t  grp_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output tsg_pkg::res_item_t   item_o
);
  import tsg_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  res_item_t          mem_q [QueueDepth];
  logic [PtrBits-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               do_pop, do_wr;

  assign empty_o = (cnt_q == '0);
  // Keep room for a whole group of results before taking the next word.
  assign full_o  = (cnt_q > (PtrBits+1)'(QueueDepth - MaxRes));
  assign item_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;
  assign do_wr   = wr_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d  = wp_q + PtrBits'(grp_i.cnt);
      cnt_d = cnt_d + (PtrBits+1)'(grp_i.cnt);
    end
    if (do_pop) begin
      rp_d  = rp_q + PtrBits'(1);
      cnt_d = cnt_d - (PtrBits+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (2'(i) < grp_i.cnt) mem_q[wp_q + PtrBits'(i)] <= grp_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/token_scanner_with_group_capture_top.sv
// Token scanner with bracket-group capture. Push one text byte per word; the scanner
// takes a word every cycle while full is low and writes the zero to three tokens it
// produces into an eight-entry result queue, which pop drains one token per cycle.
// Full rises once fewer than three queue slots are free, so sustained input rate is one
// byte per cycle as long as results are popped about as fast as they are made.
module token_scanner_with_group_capture_top #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned DEPTH_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tsg_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output tsg_pkg::res_item_t  res_item_o
);
  import tsg_pkg::*;

  res_group_t grp;
  logic       adv;

  assign adv = push && !full;

  tsg_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .item_i(in_item_i),
    .grp_o (grp)
  );

  tsg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (adv),
    .grp_i  (grp),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (res_item_o)
  );

endmodule
